@@ design/mols_pkg.sv @@
// Shared types, codes and widths for the miss-order log stream server.
package mols_pkg;

    localparam int ADDR_W       = 48;
    localparam int LOG_AW       = 16;
    localparam int LOG_DEPTH    = 1 << LOG_AW;
    localparam int RECENT_DEPTH = 8;
    localparam int RECENT_IW    = $clog2(RECENT_DEPTH);
    localparam int RECENT_CW    = $clog2(RECENT_DEPTH + 1);
    localparam int MAX_LIST     = 16;
    localparam int CNT_W        = $clog2(MAX_LIST + 1);
    localparam int LEN_W        = 5;
    localparam int BSL_W        = 4;
    localparam int REQ_W        = 6;
    localparam int TAG_W        = 8;
    localparam int QID_W        = 4;
    localparam int IN_DATA_W    = 88;
    localparam int OUT_DATA_W   = 88;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    // Input modes.
    localparam logic [1:0] MODE_MISS   = 2'd0;
    localparam logic [1:0] MODE_STREAM = 2'd1;
    localparam logic [1:0] MODE_MORE   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_MISSES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LEN   = 2'd3;

    typedef enum logic [2:0] {
        KIND_NOTIFY = 3'd0,
        KIND_LIST   = 3'd1,
        KIND_STALE  = 3'd2,
        KIND_TAIL   = 3'd3,
        KIND_EMPTY  = 3'd4
    } t_kind;

    typedef struct packed {
        logic  accept;
        logic  pos_load;
        logic  pos_inc;
        logic  rd_en;
        logic  take;
        logic  append;
        logic  emit;
        t_kind emit_kind;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        logic             enable;
        logic [1:0]       in_mode;
        logic             qualify;
        logic             dup;
        logic             addr_match;
        logic             tail_hit;
        logic             rd_zero;
        logic             limit_zero;
        logic [CNT_W-1:0] limit;
        logic             out_free;
    } t_status;

endpackage

@@ design/miss_order_log_stream_server_unit.sv @@
// Top level of the miss-order log stream server: controller, datapath and assertions.
// Throughput: one log entry per cycle while the result side keeps up, bounded by the single
// read port of the log memory; the next item is taken once the last result is registered.
// Reset (synchronous, active low) clears control state and the tail; log slots never written
// since reset read as empty through the fill pointer and wrap flag, so no clearing pass is run.
module miss_order_log_stream_server_unit import mols_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // address, location, coherence_miss, prefetch_hit, speculative_atomic, offchip,
    // requester, stream_tag, queue_id, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic [1:0]            i_s_axis_tuser,   // mode
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // address_res, location_res, requester_res, stream_tag_res, queue_id_res, new_queue,
    // zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]            o_m_axis_tuser,   // kind
    output logic                  o_m_axis_tlast
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_accept;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;

    mols_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mols_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_tdata  (i_s_axis_tdata),
        .i_in_tuser  (i_s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_tdata (o_m_axis_tdata),
        .o_out_tuser (o_m_axis_tuser),
        .o_out_tlast (o_m_axis_tlast)
    );

    // A result is only loaded when the output register is empty or being drained.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("result loaded over an untaken result");

    // An append never logs a filtered or duplicate miss.
    a_append_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.append |-> (w_status.qualify && !w_status.dup))
        else $error("append of an unqualified or recent address");

    // A transaction with the unused mode leaves the block ready for the next one.
    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_s_axis_tuser == MODE_UNUSED)) |=> o_s_axis_tready)
        else $error("unused mode started work");

    // Only list entries can be followed by more results from the same item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != KIND_LIST)) |-> o_m_axis_tlast)
        else $error("non-list result without last");

endmodule

@@ design/mols_ctrl.sv @@
// Controller state machine that sequences appends, log lookups and list streaming.
module mols_ctrl import mols_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPEND = 6'b000010,
        S_CHK    = 6'b000100,
        S_LCHK   = 6'b001000,
        S_FIN    = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_have_pend, n_have_pend;
    t_kind            r_resp_kind, n_resp_kind;
    logic [CNT_W-1:0] w_cnt_nx;

    assign w_cnt_nx   = r_cnt + 1'b1;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_have_pend = r_have_pend;
        n_resp_kind = r_resp_kind;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_have_pend  = 1'b0;
                    if (i_status.enable) begin
                        case (i_status.in_mode)
                            MODE_MISS: begin
                                n_state = S_APPEND;
                            end
                            MODE_STREAM: begin
                                o_cmd.pos_load = 1'b1;
                                o_cmd.rd_en    = 1'b1;
                                n_state        = S_CHK;
                            end
                            MODE_MORE: begin
                                o_cmd.pos_load = 1'b1;
                                o_cmd.rd_en    = 1'b1;
                                if (i_status.limit_zero) begin
                                    n_resp_kind = KIND_EMPTY;
                                    n_state     = S_RESP;
                                end else begin
                                    n_state = S_LCHK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_APPEND: begin
                if (!i_status.qualify || i_status.dup) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.append    = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_NOTIFY;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_CHK: begin
                if (!i_status.addr_match) begin
                    n_resp_kind = KIND_STALE;
                    n_state     = S_RESP;
                end else if (i_status.tail_hit) begin
                    n_resp_kind = KIND_TAIL;
                    n_state     = S_RESP;
                end else if (i_status.limit_zero) begin
                    n_resp_kind = KIND_EMPTY;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    n_state       = S_LCHK;
                end
            end
            S_LCHK: begin
                // One entry is held back until the next read shows whether it ends the list.
                if (r_have_pend) begin
                    if (i_status.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = KIND_LIST;
                        o_cmd.emit_last = i_status.rd_zero;
                        if (i_status.rd_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.take    = 1'b1;
                            o_cmd.pos_inc = 1'b1;
                            n_cnt         = w_cnt_nx;
                            if (w_cnt_nx == i_status.limit) begin
                                n_state = S_FIN;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                            end
                        end
                    end
                end else if (i_status.rd_zero) begin
                    n_resp_kind = KIND_EMPTY;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.take    = 1'b1;
                    o_cmd.pos_inc = 1'b1;
                    n_cnt         = w_cnt_nx;
                    n_have_pend   = 1'b1;
                    if (w_cnt_nx == i_status.limit) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_LIST;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = r_resp_kind;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_have_pend <= 1'b0;
            r_resp_kind <= KIND_EMPTY;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_have_pend <= n_have_pend;
            r_resp_kind <= n_resp_kind;
        end
    end

endmodule

@@ design/mols_dp.sv @@
// Datapath: configuration, log memory, recent-address filter, list registers and output stage.
module mols_dp import mols_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]   i_in_tdata,
    input  logic [1:0]             i_in_tuser,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_DATA_W-1:0]  o_out_tdata,
    output logic [2:0]             o_out_tuser,
    output logic                   o_out_tlast
);

    // Configuration.
    logic             r_enable;
    logic             r_all_misses;
    logic [BSL_W-1:0] r_block_log2;
    logic [LEN_W-1:0] r_list_len;

    // Latched input item.
    logic [ADDR_W-1:0] r_addr;
    logic [LOG_AW-1:0] r_loc;
    logic              r_coh, r_pbh, r_spec, r_offc;
    logic [REQ_W-1:0]  r_req;
    logic [TAG_W-1:0]  r_tag;
    logic [QID_W-1:0]  r_queue;
    logic              r_nq;

    // Log and its fill state.
    logic [ADDR_W-1:0] r_log [LOG_DEPTH];
    logic [LOG_AW-1:0] r_tail;
    logic              r_wrapped;
    logic [ADDR_W-1:0] r_rdata;
    logic              r_rd_ok;
    logic [LOG_AW-1:0] r_pos, n_pos;

    // Recent appends.
    logic [ADDR_W-1:0]    r_recent [RECENT_DEPTH];
    logic [RECENT_CW-1:0] r_recent_cnt;
    logic [RECENT_IW-1:0] r_recent_head;

    // Held list entry.
    logic [ADDR_W-1:0] r_pend_addr;
    logic [LOG_AW-1:0] r_pend_loc;

    // Output stage.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_tdata;
    logic [2:0]            r_out_tuser;
    logic                  r_out_tlast;

    logic [ADDR_W-1:0] w_mask, w_aligned, w_rd_val;
    logic              w_dup;
    logic [CNT_W-1:0]  w_limit;
    logic [ADDR_W-1:0] w_o_addr;
    logic [LOG_AW-1:0] w_o_loc;
    logic [REQ_W-1:0]  w_o_req;
    logic [TAG_W-1:0]  w_o_tag;
    logic [QID_W-1:0]  w_o_queue;
    logic              w_o_nq;
    logic [1:0]        w_in_mode;

    assign w_in_mode = i_in_tuser;
    assign w_mask    = ~((ADDR_W'(1) << r_block_log2) - ADDR_W'(1));
    assign w_aligned = r_addr & w_mask;
    assign w_rd_val  = r_rd_ok ? r_rdata : '0;
    assign w_limit   = (r_list_len > LEN_W'(MAX_LIST)) ? CNT_W'(MAX_LIST) : CNT_W'(r_list_len);

    always_comb begin
        w_dup = 1'b0;
        for (int i = 0; i < RECENT_DEPTH; i++) begin
            if ((RECENT_CW'(i) < r_recent_cnt) && (r_recent[i] == w_aligned)) begin
                w_dup = 1'b1;
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (i_cmd.pos_load) begin
            n_pos = i_in_tdata[63:48];
        end else if (i_cmd.pos_inc) begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_comb begin
        o_status.enable     = r_enable;
        o_status.in_mode    = w_in_mode;
        o_status.qualify    = r_coh || r_pbh || (r_offc && r_all_misses) || (r_spec && r_offc);
        o_status.dup        = w_dup;
        o_status.addr_match = (w_rd_val == r_addr);
        o_status.tail_hit   = (LOG_AW'(r_pos + 1'b1) == r_tail);
        o_status.rd_zero    = (w_rd_val == '0);
        o_status.limit_zero = (w_limit == '0);
        o_status.limit      = w_limit;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_all_misses <= 1'b0;
            r_block_log2 <= BSL_W'(6);
            r_list_len   <= LEN_W'(8);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ENABLE:     r_enable     <= i_cfg_wdata[0];
                CFG_ALL_MISSES: r_all_misses <= i_cfg_wdata[0];
                CFG_BLOCK_LOG2: r_block_log2 <= i_cfg_wdata[BSL_W-1:0];
                CFG_LIST_LEN:   r_list_len   <= i_cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr  <= i_in_tdata[47:0];
            r_loc   <= i_in_tdata[63:48];
            r_coh   <= i_in_tdata[64];
            r_pbh   <= i_in_tdata[65];
            r_spec  <= i_in_tdata[66];
            r_offc  <= i_in_tdata[67];
            r_req   <= i_in_tdata[73:68];
            r_tag   <= (w_in_mode == MODE_STREAM) ? i_in_tdata[81:74] : '0;
            r_queue <= (w_in_mode == MODE_MORE) ? i_in_tdata[85:82] : '0;
            r_nq    <= (w_in_mode == MODE_STREAM);
        end
        r_pos <= n_pos;
        if (i_cmd.take) begin
            r_pend_addr <= w_rd_val;
            r_pend_loc  <= LOG_AW'(r_pos + 1'b1);
        end
        if (i_cmd.append) begin
            r_recent[r_recent_head] <= w_aligned;
        end
    end

    // Slots at or past the tail that have not been written since reset read as empty.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_log[r_tail] <= w_aligned;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_log[n_pos];
            r_rd_ok <= r_wrapped || (n_pos < r_tail);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail        <= '0;
            r_wrapped     <= 1'b0;
            r_recent_cnt  <= '0;
            r_recent_head <= '0;
        end else if (i_cmd.append) begin
            r_tail        <= r_tail + 1'b1;
            r_recent_head <= r_recent_head + 1'b1;
            if (r_tail == '1) begin
                r_wrapped <= 1'b1;
            end
            if (r_recent_cnt < RECENT_CW'(RECENT_DEPTH)) begin
                r_recent_cnt <= r_recent_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        w_o_addr  = '0;
        w_o_loc   = r_loc;
        w_o_req   = r_req;
        w_o_tag   = r_tag;
        w_o_queue = r_queue;
        w_o_nq    = r_nq;
        case (i_cmd.emit_kind)
            KIND_NOTIFY: begin
                w_o_addr  = w_aligned;
                w_o_loc   = r_tail;
                w_o_req   = '0;
                w_o_tag   = '0;
                w_o_queue = '0;
                w_o_nq    = 1'b0;
            end
            KIND_LIST: begin
                w_o_addr = r_pend_addr;
                w_o_loc  = r_pend_loc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_tdata <= {5'b0, w_o_nq, w_o_queue, w_o_tag, w_o_req, w_o_loc, w_o_addr};
            r_out_tuser <= i_cmd.emit_kind;
            r_out_tlast <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;
    assign o_out_tlast = r_out_tlast;

endmodule
